/* hw/rtl/lmq_pkg.sv */
// ----------------------------------------------------------------------------
// lmq_pkg
// Shared codes and types for the Lamport mutex request queue: message kinds,
// register indexes, controller states and the tag word of the scan chain.
// ----------------------------------------------------------------------------
package lmq_pkg;

  // incoming message kinds (in_tuser)
  localparam logic [2:0] REQ_LOCAL = 3'd0;
  localparam logic [2:0] REL_LOCAL = 3'd1;
  localparam logic [2:0] REQ_IN    = 3'd2;
  localparam logic [2:0] REPLY_IN  = 3'd3;
  localparam logic [2:0] REL_IN    = 3'd4;
  localparam logic [2:0] DONE_IN   = 3'd5;

  // outgoing message kinds (out_tuser)
  localparam logic [1:0] SEND_NONE  = 2'd0;
  localparam logic [1:0] SEND_REQ   = 2'd1;
  localparam logic [1:0] SEND_REPLY = 2'd2;
  localparam logic [1:0] SEND_REL   = 2'd3;

  // configuration register indexes
  localparam logic [0:0] REG_OWN_ID  = 1'b0;
  localparam logic [0:0] REG_REPLIES = 1'b1;

  localparam logic [4:0] DONE_MAX = 5'd16;

  // control part of the token that travels down the cell chain
  typedef struct packed {
    logic       valid;       // token present at this cell
    logic       found;       // a live entry has been seen so far
    logic [3:0] owner;       // owner of the best entry so far
    logic [3:0] last_owner;  // owner of the top live entry
  } tok_tag_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RSCAN = 5'b00010,
    S_EVAL  = 5'b00100,
    S_GSCAN = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

endpackage

/* hw/rtl/lmq_cell.sv */
// ----------------------------------------------------------------------------
// lmq_cell
// One request table slot. Holds a (timestamp, owner) entry and passes the
// running minimum token, plus the top live entry, on to the next slot.
// ----------------------------------------------------------------------------
module lmq_cell #(
  parameter int TIME_BITS = 16,
  parameter int IDX_BITS  = 4,
  parameter int CNT_BITS  = 5,
  parameter int IDX       = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [IDX_BITS-1:0]   wr_idx,
  input  logic [TIME_BITS-1:0]  wr_time,
  input  logic [3:0]            wr_owner,
  input  logic [CNT_BITS-1:0]   cnt,
  input  lmq_pkg::tok_tag_t     in_tag,
  input  logic [TIME_BITS-1:0]  in_time,
  input  logic [IDX_BITS-1:0]   in_idx,
  input  logic [TIME_BITS-1:0]  in_last_time,
  output lmq_pkg::tok_tag_t     out_tag,
  output logic [TIME_BITS-1:0]  out_time,
  output logic [IDX_BITS-1:0]   out_idx,
  output logic [TIME_BITS-1:0]  out_last_time
);

  logic [TIME_BITS-1:0] ent_time_r;
  logic [3:0]           ent_owner_r;

  lmq_pkg::tok_tag_t    tag_r, tag_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [IDX_BITS-1:0]  idx_r, idx_nxt;
  logic [TIME_BITS-1:0] last_time_r, last_time_nxt;

  logic live, better, take, is_last;

  always_comb begin
    live    = (CNT_BITS'(IDX) < cnt);
    // ties on time go to the smaller owner; full ties keep the earlier slot
    better  = !in_tag.found || (ent_time_r < in_time) ||
              ((ent_time_r == in_time) && (ent_owner_r < in_tag.owner));
    take    = live && better;
    is_last = (CNT_BITS'(IDX + 1) == cnt);

    tag_nxt.valid      = in_tag.valid;
    tag_nxt.found      = in_tag.found | live;
    tag_nxt.owner      = take ? ent_owner_r : in_tag.owner;
    tag_nxt.last_owner = is_last ? ent_owner_r : in_tag.last_owner;
    time_nxt           = take ? ent_time_r : in_time;
    idx_nxt            = take ? IDX_BITS'(IDX) : in_idx;
    last_time_nxt      = is_last ? ent_time_r : in_last_time;
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_BITS'(IDX))) begin
      ent_time_r  <= wr_time;
      ent_owner_r <= wr_owner;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r      <= time_nxt;
    idx_r       <= idx_nxt;
    last_time_r <= last_time_nxt;
  end

  assign out_tag       = tag_r;
  assign out_time      = time_r;
  assign out_idx       = idx_r;
  assign out_last_time = last_time_r;

endmodule

/* hw/rtl/lamport_mutex_request_queue.sv */
// ----------------------------------------------------------------------------
// lamport_mutex_request_queue
// One node of Lamport mutual exclusion: Lamport clock, request table kept
// in a chain of slots, reply count, waiting flag and done count.
// ----------------------------------------------------------------------------
// Flow: a word is accepted only in the idle state. A release on a non-empty
// table first scans for the minimum and moves the top live entry into its slot;
// every word is then evaluated, and a grant check scans again when the node is
// waiting with no replies left and a non-empty table; the result then goes to
// the output register. The minimum scan walks the slot chain one slot per cycle.
// The output register lets the next word in while a result waits.
// Reset: synchronous, active low; clock, counts and flags clear, own_id and
// replies_needed return to 1; table slots hold no reset value.
module lamport_mutex_request_queue #(
  parameter int TABLE_DEPTH = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: peer_id [3:0], msg_time [19:4], zero [23:20]
  input  logic [23:0] in_tdata,
  // in_tuser: req_type [2:0]
  input  logic [2:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: send_peer [3:0], send_time [19:4], granted [20],
  //            table_error [21], finished_peers [26:22], zero [31:27]
  output logic [31:0] out_tdata,
  // out_tuser: send_kind [1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [3:0]  cfg_wdata
);

  localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int WB       = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam logic [TIME_BITS-1:0] TMAX   = '1;
  localparam logic [WB-1:0]        TMAX_W = WB'(TMAX);
  localparam logic [CNT_BITS-1:0]  CNT_FULL = CNT_BITS'(TABLE_DEPTH);

  lmq_pkg::state_t st_r, st_nxt;

  logic [TIME_BITS-1:0] clock_r, clock_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [3:0]           rleft_r, rleft_nxt;
  logic                 wait_r, wait_nxt;
  logic [4:0]           done_r, done_nxt;
  logic [3:0]           own_id_r, rneed_r;

  logic [1:0]  res_kind_r, res_kind_nxt;
  logic [3:0]  res_peer_r, res_peer_nxt;
  logic [15:0] res_time_r, res_time_nxt;
  logic        res_grant_r, res_grant_nxt;
  logic        res_err_r, res_err_nxt;

  logic [31:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;
  logic        out_v_r, out_v_nxt;

  // scan chain wiring; index k feeds slot k
  lmq_pkg::tok_tag_t    tag_w      [0:TABLE_DEPTH];
  logic [TIME_BITS-1:0] time_w     [0:TABLE_DEPTH];
  logic [IDX_BITS-1:0]  idx_w      [0:TABLE_DEPTH];
  logic [TIME_BITS-1:0] last_w     [0:TABLE_DEPTH];

  logic                 scan_start;
  logic                 wr_en;
  logic [IDX_BITS-1:0]  wr_idx;
  logic [TIME_BITS-1:0] wr_time;
  logic [3:0]           wr_owner;

  logic [2:0]           in_type;
  logic [3:0]           in_peer;
  logic [WB-1:0]        mt_w;
  logic [TIME_BITS-1:0] mt_c, base, clk_inc, base_inc, base_inc2;

  assign in_type = in_tuser;
  assign in_peer = in_tdata[3:0];
  assign mt_w    = WB'(in_tdata[19:4]);

  always_comb begin
    mt_c      = (mt_w > TMAX_W) ? TMAX : TIME_BITS'(mt_w);
    clk_inc   = (clock_r == TMAX) ? TMAX : clock_r + TIME_BITS'(1);
    base      = (mt_c > clock_r) ? mt_c : clock_r;
    base_inc  = (base == TMAX) ? TMAX : base + TIME_BITS'(1);
    base_inc2 = (base_inc == TMAX) ? TMAX : base_inc + TIME_BITS'(1);
  end

  assign in_tready = (st_r == lmq_pkg::S_IDLE);

  always_comb begin
    st_nxt        = st_r;
    clock_nxt     = clock_r;
    cnt_nxt       = cnt_r;
    rleft_nxt     = rleft_r;
    wait_nxt      = wait_r;
    done_nxt      = done_r;
    res_kind_nxt  = res_kind_r;
    res_peer_nxt  = res_peer_r;
    res_time_nxt  = res_time_r;
    res_grant_nxt = res_grant_r;
    res_err_nxt   = res_err_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    scan_start    = 1'b0;
    wr_en         = 1'b0;
    wr_idx        = cnt_r[IDX_BITS-1:0];
    wr_time       = mt_c;
    wr_owner      = in_peer;

    unique case (st_r)
      lmq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          res_kind_nxt  = lmq_pkg::SEND_NONE;
          res_peer_nxt  = 4'd0;
          res_time_nxt  = 16'd0;
          res_grant_nxt = 1'b0;
          res_err_nxt   = 1'b0;
          st_nxt        = lmq_pkg::S_EVAL;
          unique case (in_type)
            lmq_pkg::REQ_LOCAL: begin
              clock_nxt    = clk_inc;
              wr_time      = clk_inc;
              wr_owner     = own_id_r;
              if (cnt_r == CNT_FULL) begin
                res_err_nxt = 1'b1;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + CNT_BITS'(1);
              end
              wait_nxt     = 1'b1;
              rleft_nxt    = rneed_r;
              res_kind_nxt = lmq_pkg::SEND_REQ;
              res_time_nxt = 16'(clk_inc);
            end
            lmq_pkg::REL_LOCAL: begin
              clock_nxt    = clk_inc;
              wait_nxt     = 1'b0;
              rleft_nxt    = 4'd0;
              res_kind_nxt = lmq_pkg::SEND_REL;
              res_time_nxt = 16'(clk_inc);
              if (cnt_r == '0) begin
                res_err_nxt = 1'b1;
              end else begin
                scan_start = 1'b1;
                st_nxt     = lmq_pkg::S_RSCAN;
              end
            end
            lmq_pkg::REQ_IN: begin
              clock_nxt = base_inc2;
              if (cnt_r == CNT_FULL) begin
                res_err_nxt = 1'b1;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + CNT_BITS'(1);
              end
              res_kind_nxt = lmq_pkg::SEND_REPLY;
              res_peer_nxt = in_peer;
              res_time_nxt = 16'(base_inc2);
            end
            lmq_pkg::REPLY_IN: begin
              clock_nxt = base_inc;
              if (rleft_r != 4'd0) rleft_nxt = rleft_r - 4'd1;
            end
            lmq_pkg::REL_IN: begin
              clock_nxt = base_inc;
              if (rleft_r != 4'd0) rleft_nxt = rleft_r - 4'd1;
              if (cnt_r == '0) begin
                res_err_nxt = 1'b1;
              end else begin
                scan_start = 1'b1;
                st_nxt     = lmq_pkg::S_RSCAN;
              end
            end
            lmq_pkg::DONE_IN: begin
              clock_nxt = base_inc;
              if (done_r < lmq_pkg::DONE_MAX) done_nxt = done_r + 5'd1;
            end
            default: begin
            end
          endcase
        end
      end
      lmq_pkg::S_RSCAN: begin
        // move the top live entry into the minimum's slot
        if (tag_w[TABLE_DEPTH].valid) begin
          wr_en    = 1'b1;
          wr_idx   = idx_w[TABLE_DEPTH];
          wr_time  = last_w[TABLE_DEPTH];
          wr_owner = tag_w[TABLE_DEPTH].last_owner;
          cnt_nxt  = cnt_r - CNT_BITS'(1);
          st_nxt   = lmq_pkg::S_EVAL;
        end
      end
      lmq_pkg::S_EVAL: begin
        if (wait_r && (rleft_r == 4'd0) && (cnt_r != '0)) begin
          scan_start = 1'b1;
          st_nxt     = lmq_pkg::S_GSCAN;
        end else begin
          st_nxt = lmq_pkg::S_OUT;
        end
      end
      lmq_pkg::S_GSCAN: begin
        if (tag_w[TABLE_DEPTH].valid) begin
          if (tag_w[TABLE_DEPTH].owner == own_id_r) begin
            res_grant_nxt = 1'b1;
            wait_nxt      = 1'b0;
          end
          st_nxt = lmq_pkg::S_OUT;
        end
      end
      lmq_pkg::S_OUT: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt    = 1'b1;
          out_user_nxt = res_kind_r;
          out_data_nxt = {5'd0, done_r, res_err_r, res_grant_r, res_time_r, res_peer_r};
          st_nxt       = lmq_pkg::S_IDLE;
        end
      end
      default: begin
        st_nxt = lmq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= lmq_pkg::S_IDLE;
      clock_r  <= '0;
      cnt_r    <= '0;
      rleft_r  <= '0;
      wait_r   <= 1'b0;
      done_r   <= '0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      clock_r  <= clock_nxt;
      cnt_r    <= cnt_nxt;
      rleft_r  <= rleft_nxt;
      wait_r   <= wait_nxt;
      done_r   <= done_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_kind_r  <= res_kind_nxt;
    res_peer_r  <= res_peer_nxt;
    res_time_r  <= res_time_nxt;
    res_grant_r <= res_grant_nxt;
    res_err_r   <= res_err_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= 4'd1;
      rneed_r  <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lmq_pkg::REG_OWN_ID:  own_id_r <= cfg_wdata;
        lmq_pkg::REG_REPLIES: rneed_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // head of the chain: a fresh token with nothing found yet
  always_comb begin
    tag_w[0].valid      = scan_start;
    tag_w[0].found      = 1'b0;
    tag_w[0].owner      = 4'd0;
    tag_w[0].last_owner = 4'd0;
    time_w[0]           = '0;
    idx_w[0]            = '0;
    last_w[0]           = '0;
  end

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_slot
    lmq_cell #(
      .TIME_BITS (TIME_BITS),
      .IDX_BITS  (IDX_BITS),
      .CNT_BITS  (CNT_BITS),
      .IDX       (k)
    ) u_slot (
      .clk           (clk),
      .rst_n         (rst_n),
      .wr_en         (wr_en),
      .wr_idx        (wr_idx),
      .wr_time       (wr_time),
      .wr_owner      (wr_owner),
      .cnt           (cnt_r),
      .in_tag        (tag_w[k]),
      .in_time       (time_w[k]),
      .in_idx        (idx_w[k]),
      .in_last_time  (last_w[k]),
      .out_tag       (tag_w[k+1]),
      .out_time      (time_w[k+1]),
      .out_idx       (idx_w[k+1]),
      .out_last_time (last_w[k+1])
    );
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_v_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("request table count above depth");

  a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tag_w[TABLE_DEPTH].valid |-> (st_r == lmq_pkg::S_RSCAN || st_r == lmq_pkg::S_GSCAN))
    else $error("scan token arrived outside a scan");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == lmq_pkg::S_RSCAN && tag_w[TABLE_DEPTH].valid)
      |=> (cnt_r == $past(cnt_r) - CNT_BITS'(1)))
    else $error("removal did not shrink the table");

  a_grant_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == lmq_pkg::S_OUT && res_grant_r) |-> !wait_r)
    else $error("grant given while still waiting");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for one Lamport mutex node. Message words go in on the
// input stream and every accepted word is run through a behavioral model of
// the node (clock, request slots, reply count, waiting flag, done count). The
// model's outgoing message is queued and compared field by field with each
// word that leaves the output stream. Directed cases come first, then random
// request rounds under several node settings, with random gaps on both sides
// and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = 16;
  localparam int ITEM_TARGET = 1650;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;

  // message kinds the node ignores
  localparam logic [2:0] MSG_UNUSED6 = 3'd6;
  localparam logic [2:0] MSG_UNUSED7 = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  peer;
    logic [15:0] stime;
    logic        granted;
    logic        terr;
    logic [4:0]  finished;
  } send_msg_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic [23:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_we;
  logic [0:0]  cfg_idx;
  logic [3:0]  cfg_wdata;

  // node model state
  logic [3:0]  own_id_q;
  logic [3:0]  replies_needed_q;
  logic [15:0] lclock;
  logic [15:0] slot_time [TABLE_SLOTS];
  logic [3:0]  slot_owner [TABLE_SLOTS];
  int          slot_count;
  logic [3:0]  replies_left;
  bit          waiting;
  logic [4:0]  done_total;

  send_msg_t   pending_sends [$];
  int          errors;
  int          words_sent;
  bit          idle_on;
  bit          stall_on;
  int          hold_len;

  lamport_mutex_request_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // node model
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] clock_bump(logic [15:0] t);
    return (t == 16'hFFFF) ? t : t + 16'd1;
  endfunction

  function automatic bit slot_push(logic [15:0] t, logic [3:0] who);
    if (slot_count >= TABLE_SLOTS) return 1'b0;
    slot_time[slot_count] = t;
    slot_owner[slot_count] = who;
    slot_count++;
    return 1'b1;
  endfunction

  // earliest stamp, lower owner id on equal stamps
  function automatic int head_slot();
    int best;
    best = 0;
    for (int i = 1; i < slot_count; i++) begin
      if (slot_time[i] < slot_time[best] ||
          (slot_time[i] == slot_time[best] && slot_owner[i] < slot_owner[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic bit slot_pop_head();
    int m;
    if (slot_count == 0) return 1'b0;
    m = head_slot();
    slot_time[m] = slot_time[slot_count - 1];
    slot_owner[m] = slot_owner[slot_count - 1];
    slot_count--;
    return 1'b1;
  endfunction

  function automatic send_msg_t predict_send(logic [2:0] kind, logic [3:0] peer,
                                             logic [15:0] mt);
    send_msg_t r;
    r = '0;
    r.kind = lmq_pkg::SEND_NONE;
    if (kind inside {lmq_pkg::REQ_IN, lmq_pkg::REPLY_IN, lmq_pkg::REL_IN,
                     lmq_pkg::DONE_IN})
      lclock = clock_bump((mt > lclock) ? mt : lclock);
    case (kind)
      lmq_pkg::REQ_LOCAL: begin
        lclock = clock_bump(lclock);
        r.terr = !slot_push(lclock, own_id_q);
        waiting = 1'b1;
        replies_left = replies_needed_q;
        r.kind = lmq_pkg::SEND_REQ;
        r.stime = lclock;
      end
      lmq_pkg::REL_LOCAL: begin
        r.terr = !slot_pop_head();
        lclock = clock_bump(lclock);
        waiting = 1'b0;
        replies_left = 4'd0;
        r.kind = lmq_pkg::SEND_REL;
        r.stime = lclock;
      end
      lmq_pkg::REQ_IN: begin
        r.terr = !slot_push(mt, peer);
        lclock = clock_bump(lclock);
        r.kind = lmq_pkg::SEND_REPLY;
        r.peer = peer;
        r.stime = lclock;
      end
      lmq_pkg::REPLY_IN: begin
        if (replies_left != 4'd0) replies_left--;
      end
      lmq_pkg::REL_IN: begin
        r.terr = !slot_pop_head();
        if (replies_left != 4'd0) replies_left--;
      end
      lmq_pkg::DONE_IN: begin
        if (done_total < lmq_pkg::DONE_MAX) done_total++;
      end
      default: ;
    endcase
    if (waiting && replies_left == 4'd0 && slot_count > 0 &&
        slot_owner[head_slot()] == own_id_q) begin
      r.granted = 1'b1;
      waiting = 1'b0;
    end
    r.finished = done_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [3:0] rand_nibble(int lo, int hi);
    int v;
    v = $urandom_range(hi, lo);
    return v[3:0];
  endfunction

  // mostly just ahead of the local clock, some stale, a few far ahead
  function automatic logic [15:0] pick_time();
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 75) t = lclock + $urandom_range(0, 20);
    else if (r < 97) t = $urandom_range(0, lclock);
    else t = lclock + $urandom_range(0, 512);
    if (t > 65535) t = 65535;
    return t[15:0];
  endfunction

  task automatic send_word(logic [2:0] kind, logic [3:0] peer, logic [15:0] mt);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {4'd0, mt, peer};
    do @(posedge clk); while (!in_tready);
    pending_sends.push_back(predict_send(kind, peer, mt));
    if (kind <= lmq_pkg::DONE_IN) words_sent++;
  endtask

  task automatic wait_idle(int settle);
    in_tvalid <= 1'b0;
    while (pending_sends.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_node(logic [3:0] own, logic [3:0] reps);
    wait_idle(8);
    cfg_we <= 1'b1;
    cfg_idx <= lmq_pkg::REG_OWN_ID;
    cfg_wdata <= own;
    @(posedge clk);
    cfg_idx <= lmq_pkg::REG_REPLIES;
    cfg_wdata <= reps;
    @(posedge clk);
    cfg_we <= 1'b0;
    own_id_q = own;
    replies_needed_q = reps;
  endtask

  // one local request with peer traffic around it
  task automatic run_round();
    int n;
    int pick;
    logic [31:0] noise;
    repeat ($urandom_range(0, 2))
      send_word(lmq_pkg::REQ_IN, rand_nibble(0, 15), pick_time());
    send_word(lmq_pkg::REQ_LOCAL, rand_nibble(0, 15), pick_time());
    n = replies_needed_q + $urandom_range(0, 3);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) send_word(lmq_pkg::REPLY_IN, rand_nibble(0, 15), pick_time());
      else if (pick < 75) send_word(lmq_pkg::REQ_IN, rand_nibble(0, 15), pick_time());
      else if (pick < 85) send_word(lmq_pkg::REL_IN, rand_nibble(0, 15), pick_time());
      else if (pick < 92) send_word(lmq_pkg::DONE_IN, rand_nibble(0, 15), pick_time());
      else begin
        noise = $urandom;
        send_word(noise[2:0], noise[6:3], pick_time());
      end
    end
    if ($urandom_range(0, 9) != 0)
      send_word(lmq_pkg::REL_LOCAL, rand_nibble(0, 15), pick_time());
    while (slot_count > $urandom_range(0, 5))
      send_word(lmq_pkg::REL_IN, rand_nibble(0, 15), pick_time());
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  function automatic void field_check(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic check_result(logic [31:0] d, logic [1:0] u);
    send_msg_t e;
    if (pending_sends.size() == 0) begin
      $display("%0t: unexpected word tdata=%h tuser=%h", $time, d, u);
      errors++;
      return;
    end
    e = pending_sends.pop_front();
    field_check("send_kind", 16'(e.kind), 16'(u));
    field_check("send_peer", 16'(e.peer), 16'(d[3:0]));
    field_check("send_time", e.stime, d[19:4]);
    field_check("granted", 16'(e.granted), 16'(d[20]));
    field_check("table_error", 16'(e.terr), 16'(d[21]));
    field_check("finished_peers", 16'(e.finished), 16'(d[26:22]));
    field_check("pad bits", 16'd0, 16'(d[31:27]));
  endtask

  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = stall_on ? $urandom_range(0, 4) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_result(out_tdata, out_tuser);
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    logic [15:0] stamp;
    idle_on = 1'b1;
    stall_on = 1'b1;
    // empty table, nothing owed, ignored kinds
    send_word(lmq_pkg::REL_LOCAL, 4'd0, 16'd0);
    send_word(lmq_pkg::REL_IN, 4'd0, 16'd0);
    send_word(lmq_pkg::REPLY_IN, 4'd15, 16'd0);
    send_word(lmq_pkg::DONE_IN, 4'd3, 16'd0);
    send_word(MSG_UNUSED6, 4'd15, 16'hFFFF);
    send_word(MSG_UNUSED7, 4'd9, 16'h5A5A);
    // equal stamps, peer 0 is ahead of us until it releases
    send_word(lmq_pkg::REQ_LOCAL, 4'd0, 16'd0);
    stamp = lclock;
    send_word(lmq_pkg::REQ_IN, 4'd0, stamp);
    send_word(lmq_pkg::REPLY_IN, 4'd0, lclock);
    send_word(lmq_pkg::REL_IN, 4'd0, lclock);
    send_word(lmq_pkg::REL_LOCAL, 4'd0, 16'd0);
    // equal stamps, we are ahead of peer 15
    send_word(lmq_pkg::REQ_LOCAL, 4'd15, 16'hFFFF);
    stamp = lclock;
    send_word(lmq_pkg::REQ_IN, 4'd15, stamp);
    send_word(lmq_pkg::REPLY_IN, 4'd15, lclock);
    send_word(lmq_pkg::REL_LOCAL, 4'd0, lclock);
    send_word(lmq_pkg::REL_IN, 4'd15, lclock);
    send_word(lmq_pkg::REL_IN, 4'd15, lclock);
  endtask

  task automatic test_reg_extremes();
    set_node(4'd0, 4'd0);
    send_word(lmq_pkg::REQ_LOCAL, 4'd0, 16'd0);
    send_word(lmq_pkg::REL_LOCAL, 4'd0, 16'd0);
    set_node(4'd15, 4'd15);
    send_word(lmq_pkg::REQ_LOCAL, 4'd0, 16'd0);
    repeat (15) send_word(lmq_pkg::REPLY_IN, rand_nibble(0, 15), pick_time());
    send_word(lmq_pkg::REL_LOCAL, 4'd0, 16'd0);
    // release while still waiting on replies
    send_word(lmq_pkg::REQ_LOCAL, 4'd0, 16'd0);
    repeat (3) send_word(lmq_pkg::REPLY_IN, rand_nibble(0, 15), pick_time());
    send_word(lmq_pkg::REL_LOCAL, 4'd0, 16'd0);
    send_word(lmq_pkg::REPLY_IN, 4'd7, pick_time());
  endtask

  task automatic test_full_table();
    set_node(4'd15, 4'd0);
    while (slot_count > 0) send_word(lmq_pkg::REL_IN, rand_nibble(0, 15), pick_time());
    repeat (TABLE_SLOTS + 1) send_word(lmq_pkg::REQ_IN, rand_nibble(0, 15), pick_time());
    send_word(lmq_pkg::REQ_LOCAL, 4'd0, 16'd0);
    repeat (TABLE_SLOTS + 1) send_word(lmq_pkg::REL_IN, rand_nibble(0, 15), pick_time());
  endtask

  task automatic test_backpressure();
    set_node(4'd5, 4'd2);
    idle_on = 1'b0;
    stall_on = 1'b0;
    hold_len = 300;
    run_round();
    run_round();
  endtask

  task automatic test_random_rounds();
    logic [3:0] own;
    logic [3:0] reps;
    for (int phase = 0; words_sent < ITEM_TARGET; phase++) begin
      own = (phase % 3 == 0) ? 4'd0 : (phase % 3 == 1) ? 4'd15 : rand_nibble(1, 14);
      reps = (phase % 5 == 4) ? 4'd15 : (phase % 5 == 3) ? 4'd0 : rand_nibble(1, 3);
      set_node(own, reps);
      repeat (10) begin
        idle_on = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
        run_round();
      end
    end
  endtask

  // runs last: a saturated clock never comes back down
  task automatic test_clock_saturation();
    set_node(4'd1, 4'd1);
    idle_on = 1'b1;
    stall_on = 1'b1;
    while (slot_count > 0) send_word(lmq_pkg::REL_IN, rand_nibble(0, 15), pick_time());
    send_word(lmq_pkg::REQ_IN, 4'd15, 16'hFFFF);
    send_word(lmq_pkg::REQ_LOCAL, 4'd0, 16'd0);
    send_word(lmq_pkg::REQ_IN, 4'd0, 16'd0);
    send_word(lmq_pkg::REL_IN, 4'd0, 16'hFFFF);
    send_word(lmq_pkg::REPLY_IN, 4'd15, 16'hFFFF);
    send_word(lmq_pkg::REL_LOCAL, 4'd0, 16'd0);
    send_word(lmq_pkg::REL_IN, 4'd15, 16'hFFFF);
    repeat (17) send_word(lmq_pkg::DONE_IN, 4'd15, 16'hFFFF);
  endtask

  initial begin : main
    errors = 0;
    words_sent = 0;
    hold_len = 0;
    idle_on = 1'b0;
    stall_on = 1'b0;
    own_id_q = 4'd1;
    replies_needed_q = 4'd1;
    lclock = 16'd0;
    slot_count = 0;
    replies_left = 4'd0;
    waiting = 1'b0;
    done_total = 5'd0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_reg_extremes();
    test_full_table();
    test_backpressure();
    test_random_rounds();
    test_clock_saturation();

    wait_idle(DRAIN_CYCLES);
    if (errors == 0 && pending_sends.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
